@@ rtl/mrf_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the request framer.
`timescale 1ns / 1ps
package mrf_pkg;

  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam int unsigned StepW     = 4;   // longest frame run is nine bytes
  localparam int unsigned AddrW     = 4;   // three 32-bit registers at 0, 4, 8
  localparam int unsigned DataW     = 32;

  // input item kinds
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrHdr = 2'd1;
  localparam logic [1:0] KindData  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegDevAddr = 2'd0;
  localparam logic [1:0] RegRdFunc  = 2'd1;
  localparam logic [1:0] RegWrFunc  = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WHDR,
    OP_DATA,
    OP_ERR
  } op_e;

  // one classified request handed from front to back
  typedef struct packed {
    op_e         op;
    logic        crc_end;   // frame closes with CRC after this request
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  byte_val;  // byte count for a header, payload for data
  } cmd_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] rd_func;
    logic [7:0] wr_func;
  } cfg_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mrf_front.sv @@
// Front end: accepts requests, tracks the pending write and classifies each request.
`timescale 1ns / 1ps
module mrf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        start_address_i,
  input  logic [15:0]        register_count_i,
  input  logic [7:0]         byte_count_i,
  input  logic [7:0]         data_byte_i,
  output logic               cmd_push_o,
  output mrf_pkg::cmd_t      cmd_o
);

  logic [7:0] left_q, left_d;

  always_comb begin
    left_d           = left_q;
    cmd_push_o       = 1'b0;
    cmd_o.op         = mrf_pkg::OP_ERR;
    cmd_o.crc_end    = 1'b0;
    cmd_o.start      = start_address_i;
    cmd_o.count      = register_count_i;
    cmd_o.byte_val   = byte_count_i;
    if (accept_i) begin
      case (kind_i)
        mrf_pkg::KindRead: begin
          cmd_push_o    = 1'b1;
          cmd_o.op      = mrf_pkg::OP_READ;
          cmd_o.crc_end = 1'b1;
          left_d        = 8'd0;
        end
        mrf_pkg::KindWrHdr: begin
          cmd_push_o    = 1'b1;
          cmd_o.op      = mrf_pkg::OP_WHDR;
          cmd_o.crc_end = (byte_count_i == 8'd0);
          left_d        = byte_count_i;
        end
        mrf_pkg::KindData: begin
          cmd_push_o     = 1'b1;
          cmd_o.byte_val = data_byte_i;
          if (left_q == 8'd0) begin
            cmd_o.op = mrf_pkg::OP_ERR;
          end else begin
            cmd_o.op      = mrf_pkg::OP_DATA;
            cmd_o.crc_end = (left_q == 8'd1);
            left_d        = left_q - 8'd1;
          end
        end
        default: begin
          // meaningless kind: dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 8'd0;
    end else begin
      left_q <= left_d;
    end
  end

endmodule

@@ rtl/mrf_cmd_fifo.sv @@
// Small register queue of classified requests between front and back.
`timescale 1ns / 1ps
module mrf_cmd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrf_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output mrf_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mrf_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mrf_back.sv @@
// Back end: walks each request byte by byte, runs the CRC, fills the output register.
`timescale 1ns / 1ps
module mrf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mrf_pkg::cfg_t cfg_i,
  input  mrf_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    frame_byte_o,
  output logic          last_o,
  output logic          error_o
);

  logic [mrf_pkg::StepW-1:0] step_q, step_d;
  logic [mrf_pkg::StepW-1:0] n_trk, n_tot;
  logic [15:0]               crc_q, crc_d, crc_base;
  logic                      out_vld_q, out_vld_d;
  logic [7:0]                byte_q, byte_d;
  logic                      last_q, last_d, err_q, err_d;
  logic                      emit, done;
  logic [7:0]                hdr_byte;

  assign emit      = !cmd_empty_i && (!out_vld_q || pop_i);
  assign done      = (step_q == n_tot - 1'b1);
  assign cmd_pop_o = emit && done;

  always_comb begin
    case (cmd_i.op)
      mrf_pkg::OP_READ: n_trk = mrf_pkg::StepW'(6);
      mrf_pkg::OP_WHDR: n_trk = mrf_pkg::StepW'(7);
      mrf_pkg::OP_DATA: n_trk = mrf_pkg::StepW'(1);
      default:          n_trk = '0;
    endcase
    if (cmd_i.op == mrf_pkg::OP_ERR) begin
      n_tot = mrf_pkg::StepW'(1);
    end else begin
      n_tot = n_trk + (cmd_i.crc_end ? mrf_pkg::StepW'(2) : '0);
    end
  end

  always_comb begin
    case (step_q)
      mrf_pkg::StepW'(0): hdr_byte = cfg_i.dev_addr;
      mrf_pkg::StepW'(1): hdr_byte = (cmd_i.op == mrf_pkg::OP_READ) ? cfg_i.rd_func
                                                                      : cfg_i.wr_func;
      mrf_pkg::StepW'(2): hdr_byte = cmd_i.start[15:8];
      mrf_pkg::StepW'(3): hdr_byte = cmd_i.start[7:0];
      mrf_pkg::StepW'(4): hdr_byte = cmd_i.count[15:8];
      mrf_pkg::StepW'(5): hdr_byte = cmd_i.count[7:0];
      default:            hdr_byte = cmd_i.byte_val;
    endcase
  end

  // a new frame header always restarts the CRC, even over an abandoned write
  assign crc_base = ((cmd_i.op == mrf_pkg::OP_READ || cmd_i.op == mrf_pkg::OP_WHDR)
                     && step_q == '0) ? mrf_pkg::CrcPreset : crc_q;

  always_comb begin
    step_d    = step_q;
    crc_d     = crc_q;
    out_vld_d = out_vld_q;
    byte_d    = byte_q;
    last_d    = last_q;
    err_d     = err_q;
    if (emit) begin
      out_vld_d = 1'b1;
      last_d    = 1'b0;
      err_d     = 1'b0;
      step_d    = done ? '0 : step_q + 1'b1;
      if (cmd_i.op == mrf_pkg::OP_ERR) begin
        byte_d = 8'h00;
        err_d  = 1'b1;
      end else if (step_q < n_trk) begin
        byte_d = (cmd_i.op == mrf_pkg::OP_DATA) ? cmd_i.byte_val : hdr_byte;
        crc_d  = mrf_pkg::crc_feed(crc_base, byte_d);
      end else if (step_q == n_trk) begin
        byte_d = crc_q[7:0];
      end else begin
        byte_d = crc_q[15:8];
        last_d = 1'b1;
        crc_d  = mrf_pkg::CrcPreset;
      end
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      crc_q     <= mrf_pkg::CrcPreset;
      out_vld_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      crc_q     <= crc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign empty_o      = !out_vld_q;
  assign frame_byte_o = byte_q;
  assign last_o       = last_q;
  assign error_o      = err_q;

endmodule

@@ rtl/modbus_rtu_request_framer_core.sv @@
// Top level of the Modbus RTU request framer: config registers, front, queue and back.
`timescale 1ns / 1ps
// Usage:
//   Requests enter through a queue-style port: push with the fields, taken when
//   full is low. kind 0 is a read request (8 frame bytes), kind 1 a write header
//   (7 bytes, plus the CRC pair when its byte count is zero), kind 2 one write
//   data byte (echoed, followed by the CRC pair on the last one; a data byte with
//   no write pending gives a single byte flagged error). kind 3 is dropped.
//   Frame bytes leave through a queue-style port: the oldest byte is on the
//   result ports while empty is low and is taken with pop. last marks the CRC
//   high byte that closes a frame.
//   The first byte of a request passes the command queue, then the output register,
//   before it shows on the result ports. Throughput: while the receiver pops, the
//   back end writes one frame byte per cycle into the output register, one write
//   per byte of a request (1 to 9 bytes); data bytes then stream at one per cycle.
//   A command queue of CmdDepth requests decouples the two sides, so the input
//   keeps accepting while a header is still being sent. When the receiver stops
//   popping, the output register holds, the back end stalls and the queue fills
//   until full rises; nothing is lost.
//   Reset clears the queue, the output register, the pending write and the CRC,
//   and loads address 1, read code 3, write code 16. The user must write registers
//   over the APB port at byte addresses 0, 4, 8 while the block is idle (unchecked).
module modbus_rtu_request_framer_core #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request input
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 kind_i,
  input  logic [15:0]                start_address_i,
  input  logic [15:0]                register_count_i,
  input  logic [7:0]                 byte_count_i,
  input  logic [7:0]                 data_byte_i,
  // frame byte output
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 frame_byte_o,
  output logic                       last_o,
  output logic                       error_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mrf_pkg::AddrW-1:0]  paddr,
  input  logic [mrf_pkg::DataW-1:0]  pwdata,
  output logic [mrf_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  mrf_pkg::cfg_t cfg_q, cfg_d;
  mrf_pkg::cmd_t front_cmd, head_cmd;
  logic          front_push, q_empty, q_pop, q_full;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        mrf_pkg::RegDevAddr: cfg_d.dev_addr = pwdata[7:0];
        mrf_pkg::RegRdFunc:  cfg_d.rd_func  = pwdata[7:0];
        mrf_pkg::RegWrFunc:  cfg_d.wr_func  = pwdata[7:0];
        default: begin
          // unmapped address: write ignored
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mrf_pkg::RegDevAddr: prdata = {24'd0, cfg_q.dev_addr};
      mrf_pkg::RegRdFunc:  prdata = {24'd0, cfg_q.rd_func};
      mrf_pkg::RegWrFunc:  prdata = {24'd0, cfg_q.wr_func};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr <= 8'd1;
      cfg_q.rd_func  <= 8'd3;
      cfg_q.wr_func  <= 8'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- front: accept and classify ----
  assign full = q_full;

  mrf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (push && !q_full),
    .kind_i           (kind_i),
    .start_address_i  (start_address_i),
    .register_count_i (register_count_i),
    .byte_count_i     (byte_count_i),
    .data_byte_i      (data_byte_i),
    .cmd_push_o       (front_push),
    .cmd_o            (front_cmd)
  );

  // ---- request queue ----
  mrf_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .pop_i   (q_pop),
    .rdata_o (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // ---- back: byte sequencer, CRC and output register ----
  mrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (head_cmd),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_o),
    .error_o      (error_o)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the Modbus RTU request framer core.
`timescale 1ns / 1ps
module tb;
  import mrf_pkg::*;

  // kind 3 carries no meaning; the block drops it
  localparam logic [1:0] KindVoid   = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  // drain tail: idle time after the last expected byte, in which a stray frame byte is still caught
  localparam int unsigned SettleCycles = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  nbytes;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       err;
  } frame_out_t;

  // typed rows: an error request carries its single result; a kind 3 request has none
  typedef struct packed {
    request_t   req;
    logic       typed;
    frame_out_t t_out;
  } dir_row_t;

  localparam frame_out_t NoWrite = '{8'h00, 1'b0, 1'b1};
  localparam frame_out_t NoByte  = '{8'h00, 1'b0, 1'b0};

  localparam dir_row_t Directed [23] = '{
    '{'{KindData,  16'hbeef, 16'hbeef, 8'h5a, 8'h77}, 1'b1, NoWrite},  // data straight after reset
    '{'{KindVoid,  16'hffff, 16'hffff, 8'hff, 8'hff}, 1'b1, NoByte},
    '{'{KindRead,  16'h0000, 16'h0000, 8'h00, 8'h00}, 1'b0, NoByte},
    '{'{KindRead,  16'hffff, 16'hffff, 8'hff, 8'hff}, 1'b0, NoByte},
    '{'{KindWrHdr, 16'h0000, 16'h0000, 8'h00, 8'h00}, 1'b0, NoByte},   // zero byte count: CRC at once
    '{'{KindWrHdr, 16'h1234, 16'h0002, 8'h02, 8'h00}, 1'b0, NoByte},
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'h00}, 1'b0, NoByte},
    '{'{KindData,  16'hffff, 16'hffff, 8'hff, 8'hff}, 1'b0, NoByte},
    '{'{KindWrHdr, 16'hffff, 16'hffff, 8'hff, 8'h00}, 1'b0, NoByte},
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'ha5}, 1'b0, NoByte},
    '{'{KindRead,  16'h0001, 16'h007d, 8'h00, 8'h00}, 1'b0, NoByte},   // read drops the open write
    '{'{KindData,  16'h5555, 16'haaaa, 8'h01, 8'h3c}, 1'b1, NoWrite},
    '{'{KindWrHdr, 16'h0010, 16'h0003, 8'h03, 8'h00}, 1'b0, NoByte},
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'h11}, 1'b0, NoByte},
    '{'{KindVoid,  16'h0000, 16'h0000, 8'h00, 8'h99}, 1'b1, NoByte},   // dropped mid-write
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'h22}, 1'b0, NoByte},
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'h33}, 1'b0, NoByte},
    '{'{KindWrHdr, 16'h0020, 16'h0002, 8'h02, 8'h00}, 1'b0, NoByte},
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'h44}, 1'b0, NoByte},
    '{'{KindWrHdr, 16'h0030, 16'h0001, 8'h01, 8'h00}, 1'b0, NoByte},   // header drops the open write
    '{'{KindData,  16'h0000, 16'h0000, 8'h00, 8'h55}, 1'b0, NoByte},
    '{'{KindData,  16'haaaa, 16'h5555, 8'hfe, 8'hc3}, 1'b1, NoWrite},  // frame already closed
    '{'{KindVoid,  16'h5555, 16'haaaa, 8'h00, 8'h00}, 1'b1, NoByte}
  };

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 push             = 1'b0;
  logic                 full;
  logic [1:0]           kind_i           = '0;
  logic [15:0]          start_address_i  = '0;
  logic [15:0]          register_count_i = '0;
  logic [7:0]           byte_count_i     = '0;
  logic [7:0]           data_byte_i      = '0;
  logic                 empty;
  logic                 pop              = 1'b0;
  logic [7:0]           frame_byte_o;
  logic                 last_o;
  logic                 error_o;
  logic                 psel             = 1'b0;
  logic                 penable          = 1'b0;
  logic                 pwrite           = 1'b0;
  logic [AddrW-1:0]     paddr            = '0;
  logic [DataW-1:0]     pwdata           = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  modbus_rtu_request_framer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .start_address_i  (start_address_i),
    .register_count_i (register_count_i),
    .byte_count_i     (byte_count_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .frame_byte_o     (frame_byte_o),
    .last_o           (last_o),
    .error_o          (error_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --- predictor state -----------------------------------------------------
  cfg_t        frame_cfg = '{dev_addr: 8'd1, rd_func: 8'd3, wr_func: 8'd16};
  logic [15:0] crc_acc   = CrcPreset;
  logic [7:0]  bytes_left = '0;
  frame_out_t  awaited_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned fails         = 0;
  int unsigned cycles        = 0;

  // DUT outputs captured mid-cycle; nothing changes between here and the next rising edge
  logic       full_q   = 1'b1;
  logic       empty_q  = 1'b1;
  logic       pready_q = 1'b0;
  frame_out_t seen_q   = '0;

  always @(negedge clk_i) begin
    full_q   = full;
    empty_q  = empty;
    pready_q = pready;
    seen_q   = {frame_byte_o, last_o, error_o};
  end

  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    return r;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    crc_acc = crc16_modbus_byte(crc_acc, b);
    awaited_bytes.push_back('{b, 1'b0, 1'b0});
  endfunction

  // CRC goes out low byte first; the high byte closes the frame
  function automatic void put_crc();
    awaited_bytes.push_back('{crc_acc[7:0], 1'b0, 1'b0});
    awaited_bytes.push_back('{crc_acc[15:8], 1'b1, 1'b0});
    crc_acc = CrcPreset;
  endfunction

  // Frame bytes that one accepted request should produce.
  function automatic void frame_request(input request_t r);
    case (r.kind)
      KindRead, KindWrHdr: begin
        bytes_left = '0;
        crc_acc    = CrcPreset;
        put_byte(frame_cfg.dev_addr);
        put_byte(r.kind == KindRead ? frame_cfg.rd_func : frame_cfg.wr_func);
        put_byte(r.start[15:8]);
        put_byte(r.start[7:0]);
        put_byte(r.count[15:8]);
        put_byte(r.count[7:0]);
        if (r.kind == KindRead) begin
          put_crc();
        end else begin
          put_byte(r.nbytes);
          if (r.nbytes == 8'd0) begin
            put_crc();
          end else begin
            bytes_left = r.nbytes;
          end
        end
      end
      KindData: begin
        if (bytes_left == 8'd0) begin
          awaited_bytes.push_back(NoWrite);
        end else begin
          put_byte(r.data);
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) put_crc();
        end
      end
      default: ;
    endcase
  endfunction

  // --- result side -----------------------------------------------------------
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin : check_frame_bytes
    frame_out_t want;
    if (rst_ni && pop && !empty_q) begin
      if (awaited_bytes.size() == 0) begin
        $error("frame_byte: nothing expected, got %02h (last %0b error %0b)",
               seen_q.value, seen_q.last, seen_q.err);
        fails++;
      end else begin
        want = awaited_bytes.pop_front();
        if (seen_q.value !== want.value) begin
          $error("frame_byte: expected %02h, got %02h", want.value, seen_q.value);
          fails++;
        end
        if (seen_q.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, seen_q.last);
          fails++;
        end
        if (seen_q.err !== want.err) begin
          $error("error: expected %0b, got %0b", want.err, seen_q.err);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("modbus_rtu_request_framer_core regression: fail");
      $finish;
    end
  end

  // --- request side ------------------------------------------------------------
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    kind_i           <= r.kind;
    start_address_i  <= r.start;
    register_count_i <= r.count;
    byte_count_i     <= r.nbytes;
    data_byte_i      <= r.data;
    @(posedge clk_i);
    while (full_q) @(posedge clk_i);
  endtask

  task automatic issue(input request_t r);
    send_request(r);
    frame_request(r);
  endtask

  function automatic request_t random_request(input logic [1:0] k);
    request_t r;
    r.kind   = k;
    r.start  = 16'($urandom);
    r.count  = 16'($urandom);
    r.nbytes = 8'($urandom);
    r.data   = 8'($urandom);
    return r;
  endfunction

  // Mostly complete write frames with short payloads, plus reads, stray data
  // bytes, truncated writes and dropped kind 3 requests.
  task automatic random_traffic(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned ndata;
    request_t    r;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        r = random_request(KindWrHdr);
        if ($urandom_range(9) < 8) r.nbytes = 8'($urandom_range(6));
        ndata = 32'(r.nbytes);
        // long payloads and one write in ten are cut short
        if (ndata > 10 || $urandom_range(9) == 0) ndata = $urandom_range(ndata > 10 ? 10 : ndata);
        issue(r);
        sent++;
        repeat (ndata) begin
          issue(random_request(KindData));
          sent++;
        end
      end else if (pick < 80) begin
        issue(random_request(KindRead));
        sent++;
      end else if (pick < 93) begin
        issue(random_request(KindData));
        sent++;
      end else begin
        issue(random_request(KindVoid));
      end
    end
  endtask

  task automatic drain(input int unsigned tail);
    push <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // --- configuration ---------------------------------------------------------
  // setup and access phases, then idle before the next transfer
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready_q) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegDevAddr: frame_cfg.dev_addr = v;
      RegRdFunc:  frame_cfg.rd_func  = v;
      RegWrFunc:  frame_cfg.wr_func  = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(RegDevAddr, c.dev_addr);
    write_reg(RegRdFunc, c.rd_func);
    write_reg(RegWrFunc, c.wr_func);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.dev_addr = 8'($urandom);
    c.rd_func  = 8'($urandom);
    c.wr_func  = 8'($urandom);
    return c;
  endfunction

  // --- sequence ----------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests at reset configuration, no idling
    for (int i = 0; i < 23; i++) begin
      send_request(Directed[i].req);
      if (!Directed[i].typed) begin
        frame_request(Directed[i].req);
      end else if (Directed[i].req.kind != KindVoid) begin
        awaited_bytes.push_back(Directed[i].t_out);
      end
    end
    drain(SettleCycles);

    // all-ones registers, no idling
    set_config('{dev_addr: 8'hff, rd_func: 8'hff, wr_func: 8'hff});
    random_traffic(80);
    drain(SettleCycles);

    // all-zero registers, sender mostly idle; halfway it waits for the output to empty
    set_config('{dev_addr: 8'h00, rd_func: 8'h00, wr_func: 8'h00});
    send_idle_pct = 69;
    random_traffic(40);
    drain(0);
    random_traffic(40);
    drain(SettleCycles);

    // random registers, receiver mostly stalling
    set_config(random_cfg());
    send_idle_pct = 0;
    pop_stall_pct = 69;
    random_traffic(80);
    drain(SettleCycles);

    // random registers, light idling on both sides
    set_config(random_cfg());
    send_idle_pct = 14;
    pop_stall_pct = 14;
    random_traffic(80);
    drain(SettleCycles);

    if (fails == 0) begin
      $display("modbus_rtu_request_framer_core regression: pass");
    end else begin
      $display("modbus_rtu_request_framer_core regression: fail");
    end
    $finish;
  end

endmodule
